// File: src/largest_zero_square_scan_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the largest zero square scan unit
// Concurrent checks that vanish when the design is read for synthesis.
// ---------------------------------------------------------------------------
`ifndef LARGEST_ZERO_SQUARE_SCAN_UNIT_ASSERT_SVH
`define LARGEST_ZERO_SQUARE_SCAN_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define LZSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define LZSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define LZSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LZSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: src/lzss_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Largest zero square scan package
// Field widths, register indexes and the types shared between the modules.
// ---------------------------------------------------------------------------
package lzss_pkg;

    localparam int SIDE_W      = 9;
    localparam int POS_W       = 10;
    localparam int CNT_W       = 23;
    localparam int CFG_IDX_W   = 2;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 56;
    localparam int DEF_MAX_DIM = 256;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SIDE = 2'd2;

    localparam logic [SIDE_W-1:0] RST_ROWS     = 9'd256;
    localparam logic [SIDE_W-1:0] RST_COLS     = 9'd256;
    localparam logic [SIDE_W-1:0] RST_MIN_SIDE = 9'd1;
    localparam logic [POS_W-1:0]  POS_NONE     = '1;

    typedef struct packed {
        logic              valid;
        logic              frame_end;
        logic [SIDE_W-1:0] side;
        logic [SIDE_W-1:0] row;
        logic [SIDE_W-1:0] col;
    } t_cell_upd;

    typedef struct packed {
        logic [CNT_W-1:0]  square_count;
        logic [POS_W-1:0]  left_col;
        logic [POS_W-1:0]  top_row;
        logic [SIDE_W-1:0] max_side;
    } t_result;

endpackage

// File: src/lzss_line_buf.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Line buffer
// Holds the square sides of the previous row; the read of the next column
// is registered, with write-to-read forwarding when both address one entry.
// ---------------------------------------------------------------------------
module lzss_line_buf
    import lzss_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_DIM
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic [$clog2(DEPTH)-1:0]   i_wr_addr,
    input  logic [SIDE_W-1:0]          i_wr_data,
    input  logic [$clog2(DEPTH)-1:0]   i_rd_addr,
    output logic [SIDE_W-1:0]          o_rd_data
);

    logic [SIDE_W-1:0] r_mem [DEPTH];
    logic [SIDE_W-1:0] r_rd;
    logic [SIDE_W-1:0] r_fwd_data;
    logic              r_fwd;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
            r_rd             <= r_mem[i_rd_addr];
            r_fwd_data       <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_en) begin
            r_fwd <= (i_rd_addr == i_wr_addr);
        end
    end

    assign o_rd_data = r_fwd ? r_fwd_data : r_rd;

endmodule

// File: src/lzss_best_track.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Best square tracker
// Keeps the first largest side with its corner and the square count of the
// current frame, and presents the totals that include the present cell.
// ---------------------------------------------------------------------------
module lzss_best_track
    import lzss_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_upd         i_upd,
    input  logic [SIDE_W-1:0] i_min_side,
    output t_result           o_result
);

    logic [SIDE_W-1:0] r_best_side, n_best_side;
    logic [POS_W-1:0]  r_best_top,  n_best_top;
    logic [POS_W-1:0]  r_best_left, n_best_left;
    logic [CNT_W-1:0]  r_count,     n_count;

    always_comb begin
        n_best_side = r_best_side;
        n_best_top  = r_best_top;
        n_best_left = r_best_left;
        n_count     = r_count;
        if (i_upd.side > r_best_side) begin
            n_best_side = i_upd.side;
            n_best_top  = POS_W'(i_upd.row) - POS_W'(i_upd.side) + POS_W'(2);
            n_best_left = POS_W'(i_upd.col) - POS_W'(i_upd.side) + POS_W'(2);
        end
        if (i_upd.side >= i_min_side) begin
            n_count = r_count + CNT_W'(i_upd.side) - CNT_W'(i_min_side) + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_side <= '0;
            r_best_top  <= POS_NONE;
            r_best_left <= POS_NONE;
            r_count     <= '0;
        end else if (i_upd.valid) begin
            if (i_upd.frame_end) begin
                r_best_side <= '0;
                r_best_top  <= POS_NONE;
                r_best_left <= POS_NONE;
                r_count     <= '0;
            end else begin
                r_best_side <= n_best_side;
                r_best_top  <= n_best_top;
                r_best_left <= n_best_left;
                r_count     <= n_count;
            end
        end
    end

    assign o_result.max_side     = n_best_side;
    assign o_result.top_row      = n_best_top;
    assign o_result.left_col     = n_best_left;
    assign o_result.square_count = n_count;

endmodule

// File: src/largest_zero_square_scan_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Largest zero square scan unit
// Latency: the frame result is valid in the cycle after its last cell word.
// Throughput: one cell word per cycle; a waiting result stalls only the last
// cell of the next frame; the west-side min-plus-one loop closes through r_west.
// Reset: synchronous, active low; registers return to 256 rows, 256 columns
// and minimum side 1, and a new frame starts; the line buffer is not cleared.
// ---------------------------------------------------------------------------
`include "largest_zero_square_scan_unit_assert.svh"

module largest_zero_square_scan_unit
    import lzss_pkg::*;
#(
    parameter int MAX_DIM = DEF_MAX_DIM
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [0] cell_req, [7:1] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [8:0] max_side, [18:9] top_row, [28:19] left_col, [51:29] square_count,
    // [55:52] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [SIDE_W-1:0]      i_cfg_data
);

    localparam int REG_MAX = (1 << SIDE_W) - 1;
    localparam int DIM_EFF = (MAX_DIM < REG_MAX) ? MAX_DIM : REG_MAX;
    localparam int IDX_W   = $clog2(DIM_EFF);

    logic [SIDE_W-1:0] r_rows, r_cols, r_min_side;
    logic [IDX_W-1:0]  r_row, r_col;
    logic [SIDE_W-1:0] r_west, r_nw;
    logic              r_out_valid;
    t_result           r_out;

    logic [SIDE_W-1:0] w_rows_eff, w_cols_eff;
    logic [SIDE_W:0]   w_col_p1, w_row_p1;
    logic              w_last_col, w_last_row, w_last_cell, w_accept;
    logic [IDX_W-1:0]  w_col_next;
    logic [SIDE_W-1:0] w_rd_data, w_north, w_min, w_side;
    t_cell_upd         w_upd;
    t_result           w_result;

    always_comb begin
        if (r_rows == '0) begin
            w_rows_eff = SIDE_W'(1);
        end else if (r_rows > SIDE_W'(DIM_EFF)) begin
            w_rows_eff = SIDE_W'(DIM_EFF);
        end else begin
            w_rows_eff = r_rows;
        end
        if (r_cols == '0) begin
            w_cols_eff = SIDE_W'(1);
        end else if (r_cols > SIDE_W'(DIM_EFF)) begin
            w_cols_eff = SIDE_W'(DIM_EFF);
        end else begin
            w_cols_eff = r_cols;
        end
    end

    assign w_col_p1    = (SIDE_W + 1)'(r_col) + (SIDE_W + 1)'(1);
    assign w_row_p1    = (SIDE_W + 1)'(r_row) + (SIDE_W + 1)'(1);
    assign w_last_col  = (w_col_p1 >= {1'b0, w_cols_eff});
    assign w_last_row  = (w_row_p1 >= {1'b0, w_rows_eff});
    assign w_last_cell = w_last_col && w_last_row;
    assign w_col_next  = w_last_col ? '0 : IDX_W'(w_col_p1);

    assign s_axis_tready = !r_out_valid || m_axis_tready || !w_last_cell;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_north = (r_row == '0) ? '0 : w_rd_data;

    always_comb begin
        w_min = w_north;
        if (r_nw < w_min) begin
            w_min = r_nw;
        end
        if (r_west < w_min) begin
            w_min = r_west;
        end
        w_side = s_axis_tdata[0] ? '0 : w_min + SIDE_W'(1);
    end

    lzss_line_buf #(
        .DEPTH (DIM_EFF)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_accept),
        .i_wr_addr (r_col),
        .i_wr_data (w_side),
        .i_rd_addr (w_col_next),
        .o_rd_data (w_rd_data)
    );

    assign w_upd.valid     = w_accept;
    assign w_upd.frame_end = w_last_cell;
    assign w_upd.side      = w_side;
    assign w_upd.row       = SIDE_W'(r_row);
    assign w_upd.col       = SIDE_W'(r_col);

    lzss_best_track u_best_track (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_upd      (w_upd),
        .i_min_side (r_min_side),
        .o_result   (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows     <= RST_ROWS;
            r_cols     <= RST_COLS;
            r_min_side <= RST_MIN_SIDE;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_ROWS:     r_rows     <= i_cfg_data;
                REG_COLS:     r_cols     <= i_cfg_data;
                REG_MIN_SIDE: r_min_side <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_west <= '0;
            r_nw   <= '0;
        end else if (w_accept) begin
            r_col <= w_col_next;
            if (w_last_col) begin
                r_west <= '0;
                r_nw   <= '0;
                r_row  <= w_last_row ? '0 : IDX_W'(w_row_p1);
            end else begin
                r_west <= w_side;
                r_nw   <= w_north;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && w_last_cell) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_last_cell) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - $bits(t_result)){1'b0}}, r_out};

    `LZSS_ASSERT_NXT(a_last_gives_result, i_clk, i_rst_n, w_accept && w_last_cell, r_out_valid)
    `LZSS_ASSERT_IMP(a_result_from_last, i_clk, i_rst_n, $rose(r_out_valid), $past(w_accept && w_last_cell))
    `LZSS_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, !s_axis_tready, r_out_valid && !m_axis_tready)
    `LZSS_ASSERT_IMP(a_none_pos, i_clk, i_rst_n, r_out_valid, (r_out.max_side == '0) == (r_out.top_row == POS_NONE))

endmodule
